// File: hdl/rvlw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the ray voxel line walker.
// No dependencies; used by the front, back and top-level modules.
package rvlw_pkg;

   localparam int GRID_BITS      = 12;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CMP_BITS       = 17;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_COLUMNS = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_ROWS    = 1'd1;
   localparam logic [GRID_BITS-1:0]      GRID_RESET       = 12'd2048;

   typedef enum logic [2:0] {
      AXIS_X = 3'b001,
      AXIS_Y = 3'b010,
      AXIS_Z = 3'b100
   } rvlw_axis_type;

   typedef struct packed {
      rvlw_axis_type major;
      logic          neg_x;
      logic          neg_y;
      logic          neg_z;
   } rvlw_dir_type;

   typedef enum logic [1:0] {
      WALK_IDLE = 2'b01,
      WALK_RUN  = 2'b10
   } rvlw_walk_type;

   function automatic logic in_grid(input logic signed [CMP_BITS-1:0] pos,
                                    input logic [GRID_BITS-1:0] limit);
      logic [CMP_BITS-1:0] lim_ext;
      lim_ext = CMP_BITS'(limit);
      return !pos[CMP_BITS-1] && (CMP_BITS'(pos) < lim_ext);
   endfunction

endpackage

// File: hdl/ray_voxel_line_walker.sv
`timescale 1ns / 1ps
// Top level of the ray voxel line walker: configuration registers, front end,
// descriptor queue and back end. Uses rvlw_pkg, rvlw_fifo, rvlw_front, rvlw_back.
//
// Usage: write a ray (start and end voxel) with push while full is low. Each
// ray gives zero or more voxel results on the result side, read with pop
// while empty is low; the final one of a ray carries last_voxel, and also
// truncated when the walk was cut after MAX_STEPS voxels. A ray whose end
// column or row lies outside grid_columns/grid_rows gives no results.
// Throughput: one voxel per cycle while the walk runs and the result queue is
// not full. For each ray the stepping unit loads it, steps through its voxels
// and then checks for the end; it takes one ray at a time. The front end
// classifies the next rays meanwhile and holds up to two of them in its queue
// plus two in its pipeline.
// Reset clears all queues and pipelines and sets both grid registers to 2048.
// A stalled result side fills the two-entry result queue, which halts the
// stepping unit, then the ray queue, then full rises on the input.
// Write csr_ registers only while no ray is in flight.
module ray_voxel_line_walker #(
   parameter int MAX_STEPS   = 64,
   parameter int COORD_BITS  = 12,
   parameter int HEIGHT_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic signed [COORD_BITS-1:0]        req_start_x,
   input  logic signed [COORD_BITS-1:0]        req_start_y,
   input  logic signed [HEIGHT_BITS-1:0]       req_start_z,
   input  logic signed [COORD_BITS-1:0]        req_end_x,
   input  logic signed [COORD_BITS-1:0]        req_end_y,
   input  logic signed [HEIGHT_BITS-1:0]       req_end_z,
   output logic                                empty,
   input  logic                                pop,
   output logic signed [COORD_BITS-1:0]        rsp_voxel_x,
   output logic signed [COORD_BITS-1:0]        rsp_voxel_y,
   output logic signed [HEIGHT_BITS-1:0]       rsp_voxel_z,
   output logic                                rsp_inside_grid,
   output logic                                rsp_truncated,
   output logic                                rsp_last_voxel,
   input  logic                                csr_write_enable,
   input  logic [rvlw_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rvlw_pkg::GRID_BITS-1:0]      csr_write_data
);

   import rvlw_pkg::*;

   localparam int DIFF_BITS = (COORD_BITS > HEIGHT_BITS) ? COORD_BITS : HEIGHT_BITS;
   localparam int ERR_BITS  = DIFF_BITS + 3;
   localparam int DESC_BITS = $bits(rvlw_dir_type) + 4 * COORD_BITS
                              + 2 * HEIGHT_BITS + 4 * DIFF_BITS + 3 * ERR_BITS;

   logic [GRID_BITS-1:0] grid_columns_ff;
   logic [GRID_BITS-1:0] grid_rows_ff;

   logic                 desc_push;
   logic                 desc_full;
   logic [DESC_BITS-1:0] desc_in;
   logic                 desc_pop;
   logic                 desc_empty;
   logic [DESC_BITS-1:0] desc_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= GRID_RESET;
         grid_rows_ff    <= GRID_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_GRID_COLUMNS: grid_columns_ff <= csr_write_data;
            CSR_GRID_ROWS:    grid_rows_ff    <= csr_write_data;
            default: ;
         endcase
      end
   end

   rvlw_front #(
      .COORD_BITS  (COORD_BITS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .grid_columns (grid_columns_ff),
      .grid_rows    (grid_rows_ff),
      .push         (push),
      .full         (full),
      .start_x      (req_start_x),
      .start_y      (req_start_y),
      .start_z      (req_start_z),
      .end_x        (req_end_x),
      .end_y        (req_end_y),
      .end_z        (req_end_z),
      .desc_push    (desc_push),
      .desc_full    (desc_full),
      .desc_data    (desc_in)
   );

   rvlw_fifo #(
      .WIDTH (DESC_BITS),
      .DEPTH (2)
   ) u_desc_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (desc_push),
      .push_data (desc_in),
      .full      (desc_full),
      .pop       (desc_pop),
      .empty     (desc_empty),
      .pop_data  (desc_out)
   );

   rvlw_back #(
      .MAX_STEPS   (MAX_STEPS),
      .COORD_BITS  (COORD_BITS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .grid_columns (grid_columns_ff),
      .grid_rows    (grid_rows_ff),
      .desc_empty   (desc_empty),
      .desc_pop     (desc_pop),
      .desc_data    (desc_out),
      .empty        (empty),
      .pop          (pop),
      .voxel_x      (rsp_voxel_x),
      .voxel_y      (rsp_voxel_y),
      .voxel_z      (rsp_voxel_z),
      .inside_grid  (rsp_inside_grid),
      .truncated    (rsp_truncated),
      .last_voxel   (rsp_last_voxel)
   );

endmodule

// File: hdl/rvlw_fifo.sv
`timescale 1ns / 1ps
// Small register-based first-in first-out queue with push/full and pop/empty.
// No dependencies; used between front and back and at the result side.
module rvlw_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                push_ok;
   logic                pop_ok;

   assign full     = (count_ff == CNT_BITS'(DEPTH));
   assign empty    = (count_ff == '0);
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/rvlw_front.sv
`timescale 1ns / 1ps
// Front end: takes rays, checks the end cell against the grid, works out
// axis distances, driving axis and initial error terms. Uses rvlw_pkg.
module rvlw_front #(
   parameter int COORD_BITS  = 12,
   parameter int HEIGHT_BITS = 8,
   localparam int DIFF_BITS  = (COORD_BITS > HEIGHT_BITS) ? COORD_BITS : HEIGHT_BITS,
   localparam int ERR_BITS   = DIFF_BITS + 3,
   localparam int DESC_BITS  = $bits(rvlw_pkg::rvlw_dir_type) + 4 * COORD_BITS
                               + 2 * HEIGHT_BITS + 4 * DIFF_BITS + 3 * ERR_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rvlw_pkg::GRID_BITS-1:0]    grid_columns,
   input  logic [rvlw_pkg::GRID_BITS-1:0]    grid_rows,
   input  logic                              push,
   output logic                              full,
   input  logic signed [COORD_BITS-1:0]      start_x,
   input  logic signed [COORD_BITS-1:0]      start_y,
   input  logic signed [HEIGHT_BITS-1:0]     start_z,
   input  logic signed [COORD_BITS-1:0]      end_x,
   input  logic signed [COORD_BITS-1:0]      end_y,
   input  logic signed [HEIGHT_BITS-1:0]     end_z,
   output logic                              desc_push,
   input  logic                              desc_full,
   output logic [DESC_BITS-1:0]              desc_data
);

   import rvlw_pkg::*;

   // stage A: captured ray
   logic                          a_valid_ff;
   logic signed [COORD_BITS-1:0]  a_sx_ff, a_sy_ff, a_ex_ff, a_ey_ff;
   logic signed [HEIGHT_BITS-1:0] a_sz_ff, a_ez_ff;
   logic                          a_ready;
   logic                          accept;

   // stage A logic
   logic signed [COORD_BITS:0]    sub_x, sub_y;
   logic signed [HEIGHT_BITS:0]   sub_z;
   logic [COORD_BITS:0]           abs_x, abs_y;
   logic [HEIGHT_BITS:0]          abs_z;
   logic                          keep_in;

   // stage B: distances and signs
   logic                          b_valid_ff;
   logic                          b_keep_ff;
   logic signed [COORD_BITS-1:0]  b_sx_ff, b_sy_ff, b_ex_ff, b_ey_ff;
   logic signed [HEIGHT_BITS-1:0] b_sz_ff, b_ez_ff;
   logic [DIFF_BITS-1:0]          b_dx_ff, b_dy_ff, b_dz_ff;
   logic                          b_neg_x_ff, b_neg_y_ff, b_neg_z_ff;
   logic                          b_ready;
   logic                          b_leave;

   // stage B logic
   rvlw_dir_type                  dir;
   logic [DIFF_BITS-1:0]          d_major;
   logic [ERR_BITS-1:0]           err_x, err_y, err_z;

   assign a_ready = !a_valid_ff || b_ready;
   assign full    = !a_ready;
   assign accept  = push && a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_sx_ff <= start_x;
         a_sy_ff <= start_y;
         a_sz_ff <= start_z;
         a_ex_ff <= end_x;
         a_ey_ff <= end_y;
         a_ez_ff <= end_z;
      end
   end

   always_comb begin
      sub_x   = {a_ex_ff[COORD_BITS-1], a_ex_ff} - {a_sx_ff[COORD_BITS-1], a_sx_ff};
      sub_y   = {a_ey_ff[COORD_BITS-1], a_ey_ff} - {a_sy_ff[COORD_BITS-1], a_sy_ff};
      sub_z   = {a_ez_ff[HEIGHT_BITS-1], a_ez_ff} - {a_sz_ff[HEIGHT_BITS-1], a_sz_ff};
      abs_x   = sub_x[COORD_BITS] ? -sub_x : sub_x;
      abs_y   = sub_y[COORD_BITS] ? -sub_y : sub_y;
      abs_z   = sub_z[HEIGHT_BITS] ? -sub_z : sub_z;
      keep_in = in_grid(CMP_BITS'(a_ex_ff), grid_columns)
                && in_grid(CMP_BITS'(a_ey_ff), grid_rows);
   end

   assign b_leave = !b_keep_ff || !desc_full;
   assign b_ready = !b_valid_ff || b_leave;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         b_keep_ff  <= keep_in;
         b_sx_ff    <= a_sx_ff;
         b_sy_ff    <= a_sy_ff;
         b_sz_ff    <= a_sz_ff;
         b_ex_ff    <= a_ex_ff;
         b_ey_ff    <= a_ey_ff;
         b_ez_ff    <= a_ez_ff;
         b_dx_ff    <= DIFF_BITS'(abs_x[COORD_BITS-1:0]);
         b_dy_ff    <= DIFF_BITS'(abs_y[COORD_BITS-1:0]);
         b_dz_ff    <= DIFF_BITS'(abs_z[HEIGHT_BITS-1:0]);
         b_neg_x_ff <= sub_x[COORD_BITS] || (sub_x == '0);
         b_neg_y_ff <= sub_y[COORD_BITS] || (sub_y == '0);
         b_neg_z_ff <= sub_z[HEIGHT_BITS] || (sub_z == '0);
      end
   end

   always_comb begin
      dir.neg_x = b_neg_x_ff;
      dir.neg_y = b_neg_y_ff;
      dir.neg_z = b_neg_z_ff;
      if (b_dx_ff >= b_dy_ff && b_dx_ff >= b_dz_ff) begin
         dir.major = AXIS_X;
         d_major   = b_dx_ff;
      end else if (b_dy_ff >= b_dz_ff) begin
         dir.major = AXIS_Y;
         d_major   = b_dy_ff;
      end else begin
         dir.major = AXIS_Z;
         d_major   = b_dz_ff;
      end
      err_x = ERR_BITS'({b_dx_ff, 1'b0}) - ERR_BITS'(d_major);
      err_y = ERR_BITS'({b_dy_ff, 1'b0}) - ERR_BITS'(d_major);
      err_z = ERR_BITS'({b_dz_ff, 1'b0}) - ERR_BITS'(d_major);
   end

   assign desc_push = b_valid_ff && b_keep_ff;
   assign desc_data = {dir, b_sx_ff, b_sy_ff, b_sz_ff, b_ex_ff, b_ey_ff, b_ez_ff,
                       b_dx_ff, b_dy_ff, b_dz_ff, d_major, err_x, err_y, err_z};

endmodule

// File: hdl/rvlw_back.sv
`timescale 1ns / 1ps
// Back end: steps one ray voxel by voxel, holding one voxel back to mark the
// last one, and queues results. Uses rvlw_pkg and rvlw_fifo.
module rvlw_back #(
   parameter int MAX_STEPS   = 64,
   parameter int COORD_BITS  = 12,
   parameter int HEIGHT_BITS = 8,
   localparam int DIFF_BITS  = (COORD_BITS > HEIGHT_BITS) ? COORD_BITS : HEIGHT_BITS,
   localparam int ERR_BITS   = DIFF_BITS + 3,
   localparam int DESC_BITS  = $bits(rvlw_pkg::rvlw_dir_type) + 4 * COORD_BITS
                               + 2 * HEIGHT_BITS + 4 * DIFF_BITS + 3 * ERR_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [rvlw_pkg::GRID_BITS-1:0] grid_columns,
   input  logic [rvlw_pkg::GRID_BITS-1:0] grid_rows,
   input  logic                           desc_empty,
   output logic                           desc_pop,
   input  logic [DESC_BITS-1:0]           desc_data,
   output logic                           empty,
   input  logic                           pop,
   output logic signed [COORD_BITS-1:0]   voxel_x,
   output logic signed [COORD_BITS-1:0]   voxel_y,
   output logic signed [HEIGHT_BITS-1:0]  voxel_z,
   output logic                           inside_grid,
   output logic                           truncated,
   output logic                           last_voxel
);

   import rvlw_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_STEPS + 1);
   localparam int OUT_BITS = 2 * COORD_BITS + HEIGHT_BITS + 3;

   rvlw_dir_type                  q_dir;
   logic signed [COORD_BITS-1:0]  q_sx, q_sy, q_ex, q_ey;
   logic signed [HEIGHT_BITS-1:0] q_sz, q_ez;
   logic [DIFF_BITS-1:0]          q_dx, q_dy, q_dz, q_dmaj;
   logic [ERR_BITS-1:0]           q_err_x, q_err_y, q_err_z;

   rvlw_walk_type                 walk_ff;
   rvlw_walk_type                 walk_in;
   rvlw_dir_type                  dir_ff;
   logic signed [COORD_BITS-1:0]  pos_x_ff, pos_y_ff, end_x_ff, end_y_ff;
   logic signed [HEIGHT_BITS-1:0] pos_z_ff, end_z_ff;
   logic [ERR_BITS-1:0]           two_dx_ff, two_dy_ff, two_dz_ff, two_dmaj_ff;
   logic [ERR_BITS-1:0]           err_x_ff, err_y_ff, err_z_ff;
   logic [CNT_BITS-1:0]           count_ff;
   logic                          pend_valid_ff;
   logic signed [COORD_BITS-1:0]  pend_x_ff, pend_y_ff;
   logic signed [HEIGHT_BITS-1:0] pend_z_ff;
   logic                          pend_inside_ff;

   logic                          step_x, step_y, step_z;
   logic signed [COORD_BITS-1:0]  nx, ny;
   logic signed [HEIGHT_BITS-1:0] nz;
   logic [ERR_BITS-1:0]           err_x_in, err_y_in, err_z_in;
   logic                          major_done;
   logic                          hit_end;
   logic                          at_limit;
   logic                          finish;
   logic                          step_ok;
   logic                          load;
   logic                          next_inside;

   logic                          out_push;
   logic                          out_full;
   logic [OUT_BITS-1:0]           out_data;
   logic [OUT_BITS-1:0]           out_head;

   assign {q_dir, q_sx, q_sy, q_sz, q_ex, q_ey, q_ez,
           q_dx, q_dy, q_dz, q_dmaj, q_err_x, q_err_y, q_err_z} = desc_data;

   assign load     = (walk_ff == WALK_IDLE) && !desc_empty;
   assign desc_pop = load;
   assign step_ok  = (walk_ff == WALK_RUN) && !out_full;

   always_comb begin
      step_x   = (dir_ff.major == AXIS_X) || !err_x_ff[ERR_BITS-1];
      step_y   = (dir_ff.major == AXIS_Y) || !err_y_ff[ERR_BITS-1];
      step_z   = (dir_ff.major == AXIS_Z) || !err_z_ff[ERR_BITS-1];
      nx       = pos_x_ff;
      ny       = pos_y_ff;
      nz       = pos_z_ff;
      if (step_x) begin
         nx = dir_ff.neg_x ? pos_x_ff - COORD_BITS'(1) : pos_x_ff + COORD_BITS'(1);
      end
      if (step_y) begin
         ny = dir_ff.neg_y ? pos_y_ff - COORD_BITS'(1) : pos_y_ff + COORD_BITS'(1);
      end
      if (step_z) begin
         nz = dir_ff.neg_z ? pos_z_ff - HEIGHT_BITS'(1) : pos_z_ff + HEIGHT_BITS'(1);
      end
      err_x_in = err_x_ff + two_dx_ff - (step_x ? two_dmaj_ff : '0);
      err_y_in = err_y_ff + two_dy_ff - (step_y ? two_dmaj_ff : '0);
      err_z_in = err_z_ff + two_dz_ff - (step_z ? two_dmaj_ff : '0);
      case (dir_ff.major)
         AXIS_X:  major_done = (pos_x_ff == end_x_ff);
         AXIS_Y:  major_done = (pos_y_ff == end_y_ff);
         AXIS_Z:  major_done = (pos_z_ff == end_z_ff);
         default: major_done = 1'b1;
      endcase
      hit_end     = (nx == end_x_ff) && (ny == end_y_ff);
      at_limit    = (count_ff == CNT_BITS'(MAX_STEPS));
      finish      = major_done || hit_end || at_limit;
      next_inside = in_grid(CMP_BITS'(nx), grid_columns) && in_grid(CMP_BITS'(ny), grid_rows);
   end

   always_comb begin
      walk_in = walk_ff;
      case (walk_ff)
         WALK_IDLE: begin
            if (load) begin
               walk_in = WALK_RUN;
            end
         end
         WALK_RUN: begin
            if (step_ok && finish) begin
               walk_in = WALK_IDLE;
            end
         end
         default: walk_in = WALK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_ff       <= WALK_IDLE;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
      end else begin
         walk_ff <= walk_in;
         if (load) begin
            pend_valid_ff <= 1'b0;
            count_ff      <= '0;
         end else if (step_ok) begin
            pend_valid_ff <= !finish;
            if (!finish) begin
               count_ff <= count_ff + CNT_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dir_ff      <= q_dir;
         pos_x_ff    <= q_sx;
         pos_y_ff    <= q_sy;
         pos_z_ff    <= q_sz;
         end_x_ff    <= q_ex;
         end_y_ff    <= q_ey;
         end_z_ff    <= q_ez;
         two_dx_ff   <= ERR_BITS'({q_dx, 1'b0});
         two_dy_ff   <= ERR_BITS'({q_dy, 1'b0});
         two_dz_ff   <= ERR_BITS'({q_dz, 1'b0});
         two_dmaj_ff <= ERR_BITS'({q_dmaj, 1'b0});
         err_x_ff    <= q_err_x;
         err_y_ff    <= q_err_y;
         err_z_ff    <= q_err_z;
      end else if (step_ok && !finish) begin
         pos_x_ff       <= nx;
         pos_y_ff       <= ny;
         pos_z_ff       <= nz;
         err_x_ff       <= err_x_in;
         err_y_ff       <= err_y_in;
         err_z_ff       <= err_z_in;
         pend_x_ff      <= nx;
         pend_y_ff      <= ny;
         pend_z_ff      <= nz;
         pend_inside_ff <= next_inside;
      end
   end

   // release the held voxel on every step; flag it when the walk ends
   assign out_push = step_ok && pend_valid_ff;
   assign out_data = {pend_x_ff, pend_y_ff, pend_z_ff, pend_inside_ff,
                      finish && at_limit && !major_done && !hit_end, finish};

   rvlw_fifo #(
      .WIDTH (OUT_BITS),
      .DEPTH (2)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (pop),
      .empty     (empty),
      .pop_data  (out_head)
   );

   assign {voxel_x, voxel_y, voxel_z, inside_grid, truncated, last_voxel} = out_head;

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ray_voxel_line_walker: a table of directed rays, then phases
// of random rays under several grid sizes; voxels checked against the table or a walk model.
// Depends on rvlw_pkg and the ray_voxel_line_walker RTL only.
module tb;
   import rvlw_pkg::*;

   localparam int COORD_W      = 12;
   localparam int HEIGHT_W     = 8;
   localparam int MAX_STEPS    = 64;
   localparam int IDLE_PCT     = 16;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 32;
   localparam int CYCLE_LIMIT  = 500000;

   typedef struct packed {
      logic signed [COORD_W-1:0]  sx;
      logic signed [COORD_W-1:0]  sy;
      logic signed [HEIGHT_W-1:0] sz;
      logic signed [COORD_W-1:0]  ex;
      logic signed [COORD_W-1:0]  ey;
      logic signed [HEIGHT_W-1:0] ez;
   } ray_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]  x;
      logic signed [COORD_W-1:0]  y;
      logic signed [HEIGHT_W-1:0] z;
      logic                       on_grid;
      logic                       truncated;
      logic                       last;
   } voxel_type;

   typedef enum {EXP_WALK, EXP_NONE, EXP_ONE} exp_kind_type;

   typedef struct {
      int sx, sy, sz, ex, ey, ez;
      exp_kind_type kind;
      int vx, vy, vz, vin;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic full;
   logic signed [COORD_W-1:0]  req_start_x = '0;
   logic signed [COORD_W-1:0]  req_start_y = '0;
   logic signed [HEIGHT_W-1:0] req_start_z = '0;
   logic signed [COORD_W-1:0]  req_end_x = '0;
   logic signed [COORD_W-1:0]  req_end_y = '0;
   logic signed [HEIGHT_W-1:0] req_end_z = '0;
   logic empty;
   logic pop = 1'b0;
   logic signed [COORD_W-1:0]  rsp_voxel_x;
   logic signed [COORD_W-1:0]  rsp_voxel_y;
   logic signed [HEIGHT_W-1:0] rsp_voxel_z;
   logic rsp_inside_grid;
   logic rsp_truncated;
   logic rsp_last_voxel;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_GRID_COLUMNS;
   logic [GRID_BITS-1:0]      csr_write_data = '0;

   // walk model configuration and state
   logic [GRID_BITS-1:0] grid_cols = GRID_RESET;
   logic [GRID_BITS-1:0] grid_rows = GRID_RESET;
   logic [COORD_W-1:0]   stop_x = '0;
   logic [COORD_W-1:0]   stop_y = '0;
   logic [HEIGHT_W-1:0]  stop_z = '0;
   logic [13:0]          stop_err_a = '0;
   logic [13:0]          stop_err_b = '0;
   logic [6:0]           voxels_walked = '0;

   voxel_type expected_voxels[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   int  tx_idle_pct = IDLE_PCT;
   int  rx_idle_pct = IDLE_PCT;
   bit  hold_request = 1'b0;

   dir_row_type dir_table [21] = '{
      '{0, 0, 0, 2, 0, 0, EXP_ONE, 1, 0, 0, 1},
      '{5, 7, -3, 5, 9, -3, EXP_ONE, 5, 8, -3, 1},
      '{0, 0, 0, -1, 5, 0, EXP_NONE, 0, 0, 0, 0},
      '{0, 0, 0, 5, -2048, 0, EXP_NONE, 0, 0, 0, 0},
      '{100, 100, 10, 100, 100, 10, EXP_NONE, 0, 0, 0, 0},
      '{5, 5, -128, 5, 5, 127, EXP_NONE, 0, 0, 0, 0},
      '{-2, 0, 0, 0, 0, 0, EXP_ONE, -1, 0, 0, 0},
      '{2045, 0, 0, 2047, 0, 0, EXP_ONE, 2046, 0, 0, 1},
      '{-2048, -2048, -128, 0, 0, 127, EXP_WALK, 0, 0, 0, 0},
      '{2047, 2047, 127, 2047, 2000, -128, EXP_WALK, 0, 0, 0, 0},
      '{0, 0, 0, 65, 0, 0, EXP_WALK, 0, 0, 0, 0},
      '{0, 0, 0, 66, 0, 0, EXP_WALK, 0, 0, 0, 0},
      '{0, 0, 0, 10, 10, 10, EXP_WALK, 0, 0, 0, 0},
      '{10, 0, 0, 0, 10, 0, EXP_WALK, 0, 0, 0, 0},
      '{0, 10, 0, 0, 0, 10, EXP_WALK, 0, 0, 0, 0},
      '{20, 3, -5, 3, 10, 7, EXP_WALK, 0, 0, 0, 0},
      '{3, 30, 0, 9, 2, -4, EXP_WALK, 0, 0, 0, 0},
      '{1, 1, -100, 4, 6, 100, EXP_WALK, 0, 0, 0, 0},
      '{0, 0, 0, 2, 1, 50, EXP_WALK, 0, 0, 0, 0},
      '{-30, -20, 0, 5, 3, 2, EXP_WALK, 0, 0, 0, 0},
      '{2047, 2040, 127, 2047, 2047, -128, EXP_WALK, 0, 0, 0, 0}
   };

   ray_voxel_line_walker #(
      .MAX_STEPS(MAX_STEPS),
      .COORD_BITS(COORD_W),
      .HEIGHT_BITS(HEIGHT_W)
   ) DUT (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ray_voxel_line_walker test failed");
         $finish;
      end
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // Bresenham walk along the longest axis; start voxel and end column/row excluded
   function automatic void walk_ray(input ray_type r, ref voxel_type path[$]);
      int pos[3], fin[3], span[3], dir[3], err[2], minor_ax[2];
      int major_ax, count;
      bit cut;
      voxel_type v;
      pos[0] = r.sx; pos[1] = r.sy; pos[2] = r.sz;
      fin[0] = r.ex; fin[1] = r.ey; fin[2] = r.ez;
      count = 0;
      cut = 1'b0;
      if (fin[0] < 0 || fin[0] >= int'(grid_cols) || fin[1] < 0 || fin[1] >= int'(grid_rows))
         return;
      for (int i = 0; i < 3; i++) begin
         span[i] = (fin[i] > pos[i]) ? fin[i] - pos[i] : pos[i] - fin[i];
         dir[i]  = (fin[i] > pos[i]) ? 1 : -1;
      end
      if (span[0] >= span[1] && span[0] >= span[2]) begin
         major_ax = 0; minor_ax[0] = 1; minor_ax[1] = 2;
      end else if (span[1] >= span[2]) begin
         major_ax = 1; minor_ax[0] = 0; minor_ax[1] = 2;
      end else begin
         major_ax = 2; minor_ax[0] = 1; minor_ax[1] = 0;
      end
      for (int i = 0; i < 2; i++)
         err[i] = 2 * span[minor_ax[i]] - span[major_ax];
      while (pos[major_ax] != fin[major_ax]) begin
         pos[major_ax] += dir[major_ax];
         for (int i = 0; i < 2; i++) begin
            if (err[i] >= 0) begin
               pos[minor_ax[i]] += dir[minor_ax[i]];
               err[i] -= 2 * span[major_ax];
            end
            err[i] += 2 * span[minor_ax[i]];
         end
         if (pos[0] == fin[0] && pos[1] == fin[1])
            break;
         if (count >= MAX_STEPS) begin
            cut = 1'b1;
            break;
         end
         v.x = COORD_W'(pos[0]);
         v.y = COORD_W'(pos[1]);
         v.z = HEIGHT_W'(pos[2]);
         v.on_grid = pos[0] >= 0 && pos[0] < int'(grid_cols) &&
                     pos[1] >= 0 && pos[1] < int'(grid_rows);
         v.truncated = 1'b0;
         v.last = 1'b0;
         path.insert(path.size(), v);
         count++;
      end
      if (count > 0) begin
         v = path.pop_back();
         v.truncated = cut;
         v.last = 1'b1;
         path.insert(path.size(), v);
      end
      stop_x = COORD_W'(pos[0]);
      stop_y = COORD_W'(pos[1]);
      stop_z = HEIGHT_W'(pos[2]);
      stop_err_a = 14'(err[0]);
      stop_err_b = 14'(err[1]);
      voxels_walked = 7'(count);
   endfunction

   // mostly rays ending inside the grid with a nearby start; the rest all-random noise
   function automatic ray_type make_ray(input bit noise, input int reach);
      ray_type r;
      int xs, ys;
      if (noise) begin
         r = {$urandom, $urandom};
         return r;
      end
      xs = (grid_cols == 0 || grid_cols > 2048) ? 2048 : int'(grid_cols);
      ys = (grid_rows == 0 || grid_rows > 2048) ? 2048 : int'(grid_rows);
      r.ex = COORD_W'($urandom_range(xs - 1, 0));
      r.ey = COORD_W'($urandom_range(ys - 1, 0));
      r.ez = HEIGHT_W'($urandom);
      r.sx = COORD_W'(clamp(int'(r.ex) + int'($urandom_range(2 * reach)) - reach, -2048, 2047));
      r.sy = COORD_W'(clamp(int'(r.ey) + int'($urandom_range(2 * reach)) - reach, -2048, 2047));
      r.sz = HEIGHT_W'(clamp(int'(r.ez) + int'($urandom_range(2 * reach)) - reach, -128, 127));
      return r;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_ray(input ray_type r, input exp_kind_type kind, input voxel_type typed);
      voxel_type walk[$];
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push        <= 1'b1;
      req_start_x <= r.sx;
      req_start_y <= r.sy;
      req_start_z <= r.sz;
      req_end_x   <= r.ex;
      req_end_y   <= r.ey;
      req_end_z   <= r.ez;
      do @(posedge clock); while (full);
      walk_ray(r, walk);
      case (kind)
         EXP_WALK: begin
            foreach (walk[i]) expected_voxels.insert(expected_voxels.size(), walk[i]);
         end
         EXP_ONE: expected_voxels.insert(expected_voxels.size(), typed);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic run_rays(input int count);
      repeat (count)
         send_ray(make_ray($urandom_range(99) < 15, ($urandom_range(9) == 0) ? 90 : 20),
                  EXP_WALK, '0);
   endtask

   // drop push, drain outstanding voxels, then allow silent rays to clear the pipeline
   task automatic settle();
      push <= 1'b0;
      while (expected_voxels.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_grid(input logic [GRID_BITS-1:0] cols, input logic [GRID_BITS-1:0] rows);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_GRID_COLUMNS;
      csr_write_data   <= cols;
      @(negedge clock);
      csr_index        <= CSR_GRID_ROWS;
      csr_write_data   <= rows;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      grid_cols = cols;
      grid_rows = rows;
   endtask

   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         pop <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      voxel_type want;
      if (!reset && pop && !empty) begin
         if (expected_voxels.size() == 0) begin
            $error("voxel transfer with none expected: x %0d y %0d z %0d",
                   rsp_voxel_x, rsp_voxel_y, rsp_voxel_z);
            fail_count++;
         end else begin
            want = expected_voxels.pop_front();
            check_field("voxel_x", want.x, rsp_voxel_x);
            check_field("voxel_y", want.y, rsp_voxel_y);
            check_field("voxel_z", want.z, rsp_voxel_z);
            check_field("inside_grid", want.on_grid, rsp_inside_grid);
            check_field("truncated", want.truncated, rsp_truncated);
            check_field("last_voxel", want.last, rsp_last_voxel);
         end
      end
   end

   initial begin
      dir_row_type row;
      ray_type     r;
      voxel_type   typed;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_table[i]) begin
         row = dir_table[i];
         r.sx = COORD_W'(row.sx);
         r.sy = COORD_W'(row.sy);
         r.sz = HEIGHT_W'(row.sz);
         r.ex = COORD_W'(row.ex);
         r.ey = COORD_W'(row.ey);
         r.ez = HEIGHT_W'(row.ez);
         typed.x = COORD_W'(row.vx);
         typed.y = COORD_W'(row.vy);
         typed.z = HEIGHT_W'(row.vz);
         typed.on_grid = row.vin[0];
         typed.truncated = 1'b0;
         typed.last = 1'b1;
         send_ray(r, row.kind, typed);
      end

      settle();
      set_grid(12'd1, 12'd1);
      run_rays(40);

      settle();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_grid(12'd4095, 12'd4095);
      run_rays(80);

      settle();
      tx_idle_pct = IDLE_PCT;
      rx_idle_pct = IDLE_PCT;
      set_grid(12'd0, 12'd2048);
      run_rays(10);

      settle();
      set_grid(12'd2048, 12'd1);
      hold_request = 1'b1;
      run_rays(60);

      repeat (3) begin
         settle();
         set_grid(12'($urandom_range(2048, 1)), 12'($urandom_range(2048, 1)));
         run_rays(70);
      end

      settle();
      if (fail_count == 0)
         $display("ray_voxel_line_walker test passed");
      else
         $display("ray_voxel_line_walker test failed");
      $finish;
   end

endmodule
